>>> sv/sirb_pkg.sv
// shared types and constants of the sorted insert list
`default_nettype none

package sirb_pkg;

   // default list size and key width
   localparam int DEPTH_DEFAULT     = 64;
   localparam int KEY_WIDTH_DEFAULT = 6;

   // width of the rank field of a result
   localparam int POS_WIDTH = 6;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load;   // latch a new key and set up the listing
      logic step;   // handle one entry and load the result register
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic out_free;  // result register can take a new transaction
      logic last;      // entry under work is the final one of the listing
   } status_type;

endpackage

`default_nettype wire

>>> sv/sirb_ctrl.sv
// controller state machine of the sorted insert list
`default_nettype none

module sirb_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire sirb_pkg::status_type status,
   output sirb_pkg::cmd_type         cmd
);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_FETCH = 3'b010,
      ST_EMIT  = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;

   // handshake and commands
   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      cmd.load  = req_valid && (state_ff == ST_IDLE);
      cmd.step  = (state_ff == ST_EMIT) && status.out_free;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free && status.last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

>>> sv/sirb_dpath.sv
// datapath of the sorted insert list: list memory, merge logic, result register
`default_nettype none

module sirb_dpath #(
   parameter int DEPTH     = sirb_pkg::DEPTH_DEFAULT,
   parameter int KEY_WIDTH = sirb_pkg::KEY_WIDTH_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic [KEY_WIDTH-1:0]           req_key,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic [KEY_WIDTH-1:0]                rsp_entry_value,
   output logic [sirb_pkg::POS_WIDTH-1:0]      rsp_entry_position,
   output logic                                rsp_last_entry,
   output logic                                rsp_insert_dropped,
   input  wire sirb_pkg::cmd_type              cmd,
   output sirb_pkg::status_type                status
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   // list memory, ascending from address 0
   logic [KEY_WIDTH-1:0] mem [DEPTH];

   logic [KEY_WIDTH-1:0] rdata_ff;
   logic [IDX_W-1:0]     rd_addr;

   logic [CNT_W-1:0]     count_ff;
   logic [CNT_W-1:0]     total_ff;
   logic [CNT_W-1:0]     total_in;
   logic                 drop_ff;
   logic                 drop_in;
   logic [KEY_WIDTH-1:0] key_ff;
   logic [IDX_W-1:0]     idx_ff;
   logic [KEY_WIDTH-1:0] carry_ff;
   logic                 inserted_ff;

   logic                 last;
   logic                 wr_en;
   logic [KEY_WIDTH-1:0] emit_val;
   logic                 take_key;

   logic                              rsp_valid_ff;
   logic [KEY_WIDTH-1:0]              rsp_value_ff;
   logic [sirb_pkg::POS_WIDTH-1:0]    rsp_pos_ff;
   logic                              rsp_last_ff;
   logic                              rsp_drop_ff;

   // listing setup for a new key
   always_comb begin
      drop_in  = (count_ff == CNT_W'(DEPTH));
      total_in = drop_in ? count_ff : count_ff + CNT_W'(1);
   end

   // merge of the new key into the ascending walk
   always_comb begin
      last     = ((CNT_W'(idx_ff) + CNT_W'(1)) == total_ff);
      take_key = 1'b0;
      emit_val = rdata_ff;
      if (drop_ff) begin
         emit_val = rdata_ff;
      end else if (last) begin
         emit_val = inserted_ff ? carry_ff : key_ff;
      end else if (inserted_ff) begin
         emit_val = carry_ff;
      end else if (rdata_ff > key_ff) begin
         emit_val = key_ff;
         take_key = 1'b1;
      end
      wr_en = cmd.step && !drop_ff;
   end

   // read address runs one entry ahead once the current one is handled
   assign rd_addr = cmd.step ? idx_ff + IDX_W'(1) : idx_ff;

   // list memory ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[idx_ff] <= emit_val;
      end
      rdata_ff <= mem[rd_addr];
   end

   // entry count
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.load) begin
         count_ff <= total_in;
      end
   end

   // walk state
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         key_ff      <= req_key;
         drop_ff     <= drop_in;
         total_ff    <= total_in;
         idx_ff      <= '0;
         inserted_ff <= 1'b0;
      end else if (cmd.step) begin
         idx_ff <= idx_ff + IDX_W'(1);
         if (take_key || inserted_ff) begin
            carry_ff <= rdata_ff;
         end
         if (take_key) begin
            inserted_ff <= 1'b1;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.step) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.step) begin
         rsp_value_ff <= emit_val;
         rsp_pos_ff   <= sirb_pkg::POS_WIDTH'(idx_ff);
         rsp_last_ff  <= last;
         rsp_drop_ff  <= drop_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_entry_value    = rsp_value_ff;
   assign rsp_entry_position = rsp_pos_ff;
   assign rsp_last_entry     = rsp_last_ff;
   assign rsp_insert_dropped = rsp_drop_ff;

   // status to the controller
   always_comb begin
      status.out_free = !rsp_valid_ff || rsp_ready;
      status.last     = last;
   end

endmodule

`default_nettype wire

>>> sv/sorted_insert_ring_buffer_core.sv
// top level of the sorted insert list
`default_nettype none

// Keeps an ascending list of up to DEPTH keys. Each request transaction
// carries one key; it is placed after every equal entry, and the whole list
// is then returned as one response transaction per entry, in ascending
// order, with its rank and a flag on the final entry. When the list is
// already full the key is discarded, the list is returned unchanged and
// every response of that listing has insert_dropped set. Insertion and
// readout share one ascending walk over a single list memory, one entry a
// cycle while the output register can take it; after acceptance and a
// memory read, a request holding the list at n entries before it yields
// n + 1 responses, or n when the list is already full and the key is
// dropped. A new request is taken once the last response of the previous
// listing has been loaded into the output register.
module sorted_insert_ring_buffer_core #(
   parameter int DEPTH     = sirb_pkg::DEPTH_DEFAULT,
   parameter int KEY_WIDTH = sirb_pkg::KEY_WIDTH_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [KEY_WIDTH-1:0]           req_key,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic [KEY_WIDTH-1:0]                rsp_entry_value,
   output logic [sirb_pkg::POS_WIDTH-1:0]      rsp_entry_position,
   output logic                                rsp_last_entry,
   output logic                                rsp_insert_dropped
);

   sirb_pkg::cmd_type    cmd;
   sirb_pkg::status_type status;

   // sequencing
   sirb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // list storage and result path
   sirb_dpath #(
      .DEPTH     (DEPTH),
      .KEY_WIDTH (KEY_WIDTH)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .req_key            (req_key),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_entry_value    (rsp_entry_value),
      .rsp_entry_position (rsp_entry_position),
      .rsp_last_entry     (rsp_last_entry),
      .rsp_insert_dropped (rsp_insert_dropped),
      .cmd                (cmd),
      .status             (status)
   );

endmodule

`default_nettype wire
